/* rtl/core/bffa_pkg.sv */
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types and codes for the bitmap first-fit block allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

	// blocks held in one bitmap memory word
	localparam int unsigned WORD_W = 8;
	// width of block pointers and run lengths
	localparam int unsigned PW = 26;

	localparam logic [1:0] CMD_INIT  = 2'd0;
	localparam logic [1:0] CMD_ALLOC = 2'd1;
	localparam logic [1:0] CMD_FREE  = 2'd2;
	// unused code, answered as done with nothing changed
	localparam logic [1:0] CMD_NOP   = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FAIL = 2'd1;
	localparam logic [1:0] ST_NULL = 2'd2;

	localparam logic REG_TOTAL    = 1'b0;
	localparam logic REG_RESERVED = 1'b1;

	typedef enum logic [3:0] {
		S_RST_CLR,
		S_IDLE,
		S_INIT,
		S_ARD,
		S_ASCAN,
		S_MRD,
		S_MWR,
		S_FRD,
		S_FPROC,
		S_DONE
	} state_t;

	typedef struct packed {
		logic       load;
		logic       sweep_wr;
		logic       rd_en;
		logic       scan_step;
		logic       mark_wr;
		logic       free_step;
		logic       st_we;
		logic [1:0] st_code;
	} ctl_t;

	typedef struct packed {
		logic sweep_last;
		logic want_zero;
		logic addr_null;
		logic free_in_lim;
		logic found;
		logic scan_end;
		logic mark_last;
		logic free_more;
	} sts_t;

endpackage

/* rtl/core/bffa_ram.sv */
// ----------------------------------------------------------------------------
// bffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bffa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 512,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/bffa_ctrl.sv */
// ----------------------------------------------------------------------------
// bffa_ctrl
// Command sequencer: clearing pass, scan, mark and free loops.
// ----------------------------------------------------------------------------
module bffa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        command,
	input  bffa_pkg::sts_t    sts,
	output bffa_pkg::ctl_t    ctl,
	output logic              busy,
	output logic              done
);

	bffa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bffa_pkg::S_RST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bffa_pkg::S_RST_CLR: if (sts.sweep_last) state_d = bffa_pkg::S_IDLE;
			bffa_pkg::S_IDLE: begin
				if (start) begin
					unique case (command)
						bffa_pkg::CMD_INIT:  state_d = bffa_pkg::S_INIT;
						bffa_pkg::CMD_ALLOC: state_d = sts.want_zero ? bffa_pkg::S_DONE
							: bffa_pkg::S_ARD;
						bffa_pkg::CMD_FREE:  state_d = (sts.addr_null || !sts.free_in_lim)
							? bffa_pkg::S_DONE : bffa_pkg::S_FRD;
						default:             state_d = bffa_pkg::S_DONE;
					endcase
				end
			end
			bffa_pkg::S_INIT: if (sts.sweep_last) state_d = bffa_pkg::S_DONE;
			bffa_pkg::S_ARD:  state_d = bffa_pkg::S_ASCAN;
			bffa_pkg::S_ASCAN: begin
				priority if (sts.found) state_d = bffa_pkg::S_MRD;
				else if (sts.scan_end)  state_d = bffa_pkg::S_DONE;
				else                    state_d = bffa_pkg::S_ARD;
			end
			bffa_pkg::S_MRD: state_d = bffa_pkg::S_MWR;
			bffa_pkg::S_MWR: state_d = sts.mark_last ? bffa_pkg::S_DONE : bffa_pkg::S_MRD;
			bffa_pkg::S_FRD: state_d = bffa_pkg::S_FPROC;
			bffa_pkg::S_FPROC: state_d = sts.free_more ? bffa_pkg::S_FRD : bffa_pkg::S_DONE;
			bffa_pkg::S_DONE: state_d = bffa_pkg::S_IDLE;
			default: state_d = bffa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.st_code = bffa_pkg::ST_DONE;
		busy = (state_q != bffa_pkg::S_IDLE);
		done = (state_q == bffa_pkg::S_DONE);
		unique case (state_q)
			bffa_pkg::S_RST_CLR, bffa_pkg::S_INIT: ctl.sweep_wr = 1'b1;
			bffa_pkg::S_IDLE: begin
				ctl.load = start;
				if (start && command == bffa_pkg::CMD_ALLOC && sts.want_zero) begin
					ctl.st_we   = 1'b1;
					ctl.st_code = bffa_pkg::ST_FAIL;
				end
				if (start && command == bffa_pkg::CMD_FREE && sts.addr_null) begin
					ctl.st_we   = 1'b1;
					ctl.st_code = bffa_pkg::ST_NULL;
				end
			end
			bffa_pkg::S_ARD, bffa_pkg::S_MRD, bffa_pkg::S_FRD: ctl.rd_en = 1'b1;
			bffa_pkg::S_ASCAN: begin
				ctl.scan_step = 1'b1;
				if (!sts.found && sts.scan_end) begin
					ctl.st_we   = 1'b1;
					ctl.st_code = bffa_pkg::ST_FAIL;
				end
			end
			bffa_pkg::S_MWR:   ctl.mark_wr = 1'b1;
			bffa_pkg::S_FPROC: ctl.free_step = 1'b1;
			default: ;
		endcase
	end

endmodule

/* rtl/core/bffa_dp.sv */
// ----------------------------------------------------------------------------
// bffa_dp
// Datapath: config registers, bitmap memory, run counter and used count.
// ----------------------------------------------------------------------------
module bffa_dp #(
	parameter int unsigned MAX_BLOCKS  = 4096,
	parameter int unsigned BLOCK_SHIFT = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [12:0]       cfg_data,
	input  logic [1:0]        command,
	input  logic [24:0]       size_bytes,
	input  logic [23:0]       address,
	input  bffa_pkg::ctl_t    ctl,
	output bffa_pkg::sts_t    sts,
	output logic [1:0]        status,
	output logic [23:0]       result_address,
	output logic [12:0]       used_count
);

	localparam int unsigned PW    = bffa_pkg::PW;
	localparam int unsigned WW    = bffa_pkg::WORD_W;
	localparam int unsigned DEPTH = (MAX_BLOCKS + WW - 1) / WW;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned BW    = $clog2(MAX_BLOCKS + 1);
	localparam logic [PW-1:0] MAXP      = PW'(MAX_BLOCKS);
	localparam logic [PW-1:0] LAST_BASE = PW'((DEPTH - 1) * WW);
	localparam logic [PW-1:0] RND       = PW'((64'd1 << BLOCK_SHIFT) - 64'd1);

	logic [12:0]   total_q, reserved_q;
	logic [PW-1:0] ptr_q, run_q, first_q, want_q, start_q, end_q, n_q;
	logic [BW-1:0] used_q;
	logic [1:0]    status_q;
	logic [23:0]   ra_q;

	logic [PW-1:0] lim, base, want_in, blk_in, resv_lim;
	logic [WW-1:0] rdata, wdata;
	logic          we;
	logic [AW-1:0] waddr;

	// scan results
	logic [PW-1:0] s_run, s_first, s_blk;
	logic          s_found;
	// free results
	logic [WW-1:0] f_word;
	logic [3:0]    f_cnt;
	logic          f_go;
	logic [WW-1:0] m_word;
	logic [31:0]   used_w;
	logic [63:0]   ra_w;

	assign lim      = (PW'(total_q) > MAXP) ? MAXP : PW'(total_q);
	assign resv_lim = (PW'(reserved_q) > MAXP) ? MAXP : PW'(reserved_q);
	assign base     = {ptr_q[PW-1:3], 3'b000};
	assign want_in  = (PW'(size_bytes) + RND) >> BLOCK_SHIFT;
	assign blk_in   = PW'(address >> BLOCK_SHIFT);
	assign waddr    = base[AW+2:3];

	always_comb begin
		s_run   = run_q;
		s_first = first_q;
		s_found = 1'b0;
		for (int j = 0; j < WW; j++) begin
			s_blk = base + PW'(j);
			if (!s_found && s_blk < lim) begin
				if (!rdata[j]) begin
					if (s_run == '0) s_first = s_blk;
					s_run = s_run + PW'(1);
					if (s_run == want_q) s_found = 1'b1;
				end else begin
					s_run = '0;
				end
			end
		end
	end

	always_comb begin
		f_word = rdata;
		f_cnt  = '0;
		f_go   = 1'b1;
		m_word = rdata;
		for (int j = 0; j < WW; j++) begin
			if ((base + PW'(j)) >= ptr_q && f_go) begin
				if ((base + PW'(j)) < lim && rdata[j]) begin
					f_word[j] = 1'b0;
					f_cnt     = f_cnt + 4'd1;
				end else begin
					f_go = 1'b0;
				end
			end
			if ((base + PW'(j)) >= start_q && (base + PW'(j)) < end_q) begin
				m_word[j] = 1'b1;
			end
		end
		for (int j = 0; j < WW; j++) begin
			wdata[j] = (ctl.sweep_wr) ? ((base + PW'(j)) < n_q) : 1'b0;
		end
		if (ctl.mark_wr) wdata = m_word;
		if (ctl.free_step) wdata = f_word;
	end

	assign we = ctl.sweep_wr | ctl.mark_wr | ctl.free_step;

	bffa_ram #(.WIDTH(WW), .DEPTH(DEPTH), .AW(AW)) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (ctl.rd_en),
		.raddr (waddr),
		.rdata (rdata)
	);

	always_comb begin
		sts.sweep_last  = (base >= LAST_BASE);
		sts.want_zero   = (want_in == '0);
		sts.addr_null   = (address == '0);
		sts.free_in_lim = (blk_in < lim);
		sts.found       = s_found;
		sts.scan_end    = ((base + PW'(WW)) >= lim);
		sts.mark_last   = ((base + PW'(WW)) >= end_q);
		sts.free_more   = f_go && ((base + PW'(WW)) < lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= 13'd4096;
			reserved_q <= '0;
			ptr_q      <= '0;
			run_q      <= '0;
			first_q    <= '0;
			want_q     <= '0;
			start_q    <= '0;
			end_q      <= '0;
			n_q        <= '0;
			used_q     <= '0;
			status_q   <= bffa_pkg::ST_DONE;
			ra_q       <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == bffa_pkg::REG_TOTAL) total_q <= cfg_data;
				else reserved_q <= cfg_data;
			end
			if (ctl.load) begin
				status_q <= bffa_pkg::ST_DONE;
				ra_q     <= '0;
				run_q    <= '0;
				want_q   <= want_in;
				ptr_q    <= (command == bffa_pkg::CMD_FREE) ? blk_in : '0;
				if (command == bffa_pkg::CMD_INIT) begin
					n_q    <= resv_lim;
					used_q <= BW'(resv_lim);
				end
			end
			if (ctl.st_we) status_q <= ctl.st_code;
			if (ctl.sweep_wr) ptr_q <= base + PW'(WW);
			if (ctl.scan_step) begin
				if (s_found) begin
					ptr_q   <= s_first;
					start_q <= s_first;
					end_q   <= s_first + want_q;
				end else begin
					ptr_q   <= base + PW'(WW);
					run_q   <= s_run;
					first_q <= s_first;
				end
			end
			if (ctl.mark_wr) begin
				ptr_q <= base + PW'(WW);
				if (sts.mark_last) begin
					used_q <= used_q + BW'(want_q);
					ra_q   <= ra_w[23:0];
				end
			end
			if (ctl.free_step) begin
				ptr_q  <= base + PW'(WW);
				used_q <= used_q - BW'(f_cnt);
			end
		end
	end

	assign ra_w           = 64'(start_q) << BLOCK_SHIFT;
	assign used_w         = 32'(used_q);
	assign status         = status_q;
	assign result_address = ra_q;
	assign used_count     = used_w[12:0];

endmodule

/* rtl/core/bitmap_first_fit_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator_core
// First-fit block allocator over a used-bit map held in block RAM.
// ----------------------------------------------------------------------------
// The map sits in a RAM of 8-block words. Allocate reads and scans words up
// to the fit, then reads and writes back each word that it marks; free reads
// and writes back each word that it clears; init writes every word, marking
// the reserved blocks used. After reset a clearing pass over the whole map
// runs with busy high. One result word appears on done for a single
// cycle and the receiver cannot stall it; start is taken only when busy is low.
module bitmap_first_fit_block_allocator_core #(
	parameter int unsigned MAX_BLOCKS  = 4096,
	parameter int unsigned BLOCK_SHIFT = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [24:0] size_bytes,
	input  logic [23:0] address,
	output logic        done,
	output logic [1:0]  status,
	output logic [23:0] result_address,
	output logic [12:0] used_count
);

	bffa_pkg::ctl_t ctl;
	bffa_pkg::sts_t sts;

	bffa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.sts     (sts),
		.ctl     (ctl),
		.busy    (busy),
		.done    (done)
	);

	bffa_dp #(.MAX_BLOCKS(MAX_BLOCKS), .BLOCK_SHIFT(BLOCK_SHIFT)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.command        (command),
		.size_bytes     (size_bytes),
		.address        (address),
		.ctl            (ctl),
		.sts            (sts),
		.status         (status),
		.result_address (result_address),
		.used_count     (used_count)
	);

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives init, allocate, free and NOP commands into the first-fit block
// allocator under several map sizes and reserved counts; checks status,
// address and used count against a table or its own bitmap model (random).
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned NBLK   = 4096;
	localparam int unsigned BSHIFT = 12;
	localparam int unsigned LIMIT  = 10000000;
	localparam int unsigned N_RAND = 1000;

	typedef struct packed {
		logic [1:0]  st;
		logic [23:0] ra;
		logic [12:0] cnt;
	} outcome_t;

	typedef struct {
		logic [1:0]  cmd;
		logic [24:0] sz;
		logic [23:0] ad;
		outcome_t    want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [12:0] cfg_data;
	logic        start;
	logic        busy;
	logic [1:0]  command;
	logic [24:0] size_bytes;
	logic [23:0] address;
	logic        done;
	logic [1:0]  status;
	logic [23:0] result_address;
	logic [12:0] used_count;

	bitmap_first_fit_block_allocator_core DUT (.*);

	// allocator model state
	bit          map_used [NBLK];
	int unsigned model_used;
	int unsigned total_cfg;
	int unsigned reserved_cfg;

	outcome_t    pending [$];
	logic [23:0] live_addrs [$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned words_checked = 0;
	int unsigned allocs_ok;
	int unsigned frees_ok;
	int unsigned burst_left;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	task automatic run_command(input logic [1:0] c, input logic [24:0] sz,
			input logic [23:0] ad, output outcome_t o);
		int unsigned lim;
		int unsigned want;
		int unsigned run;
		int unsigned first;
		int unsigned b;
		bit found;
		lim = (total_cfg > NBLK) ? NBLK : total_cfg;
		o = '0;
		found = 0;
		run = 0;
		first = 0;
		case (c)
			bffa_pkg::CMD_INIT: begin
				model_used = 0;
				for (int i = 0; i < NBLK; i++) begin
					map_used[i] = (i < reserved_cfg);
					if (i < reserved_cfg) model_used++;
				end
			end
			bffa_pkg::CMD_ALLOC: begin
				want = (int'(sz) + (1 << BSHIFT) - 1) >> BSHIFT;
				if (want != 0) begin
					for (int i = 0; i < lim && !found; i++) begin
						if (!map_used[i]) begin
							if (run == 0) first = i;
							run++;
							if (run == want) found = 1;
						end else begin
							run = 0;
						end
					end
				end
				if (!found) begin
					o.st = bffa_pkg::ST_FAIL;
				end else begin
					for (int k = 0; k < want; k++) map_used[first + k] = 1;
					model_used += want;
					o.ra = 24'(first << BSHIFT);
					allocs_ok++;
					live_addrs.push_back(o.ra | 24'($urandom_range(0, 4095)));
				end
			end
			bffa_pkg::CMD_FREE: begin
				if (ad == 0) begin
					o.st = bffa_pkg::ST_NULL;
				end else begin
					b = 32'(ad) >> BSHIFT;
					while (b < lim && map_used[b]) begin
						map_used[b] = 0;
						model_used--;
						b++;
					end
					frees_ok++;
				end
			end
			default: ;
		endcase
		o.cnt = model_used[12:0];
	endtask

	// one word per call; held until the allocator is free to take it
	task automatic send(input logic [1:0] c, input logic [24:0] sz,
			input logic [23:0] ad, input bit typed, input outcome_t typed_exp);
		outcome_t o;
		while (busy) @(negedge clk);
		start <= 1'b1;
		command <= c;
		size_bytes <= sz;
		address <= ad;
		run_command(c, sz, ad, o);
		pending.push_back(typed ? typed_exp : o);
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain;
		start <= 1'b0;
		while (pending.size() != 0) @(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input int unsigned v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[12:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == bffa_pkg::REG_TOTAL) total_cfg = 32'(v[12:0]);
		else reserved_cfg = 32'(v[12:0]);
	endtask

	task automatic random_word;
		int unsigned pick;
		int unsigned j;
		logic [1:0]  c;
		logic [24:0] sz;
		logic [23:0] ad;
		pick = $urandom_range(0, 99);
		sz = 25'($urandom);
		ad = 24'($urandom);
		if (pick < 48) begin
			c = bffa_pkg::CMD_ALLOC;
			pick = $urandom_range(0, 99);
			if (pick < 70) sz = 25'($urandom_range(1, 8 << BSHIFT));
			else if (pick < 85) sz = 25'($urandom_range(1, 64 << BSHIFT));
			else if (pick < 90) sz = '0;
			else if (pick < 95) sz = 25'($urandom_range(0, 1 << 24));
		end else if (pick < 88) begin
			c = bffa_pkg::CMD_FREE;
			pick = $urandom_range(0, 99);
			if (pick < 70 && live_addrs.size() != 0) begin
				j = $urandom_range(0, live_addrs.size() - 1);
				ad = live_addrs[j];
				live_addrs.delete(j);
			end else if (pick < 80) begin
				ad = '0;
			end
		end else if (pick < 94) begin
			c = bffa_pkg::CMD_INIT;
			live_addrs.delete();
		end else begin
			c = bffa_pkg::CMD_NOP;
		end
		send(c, sz, ad, 0, '0);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && done) begin
			words_checked <= words_checked + 1;
			if (pending.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected result word at cycle %0d", cycles);
			end else begin
				e = pending.pop_front();
				if (status !== e.st || result_address !== e.ra || used_count !== e.cnt) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: exp st=%0d addr=%h cnt=%0d got st=%0d addr=%h cnt=%0d",
							e.st, e.ra, e.cnt, status, result_address, used_count);
				end
			end
		end
	end

	row_t directed [$] = '{
		'{bffa_pkg::CMD_INIT,  25'd0,       24'h0,
			'{bffa_pkg::ST_DONE, 24'h0,    13'd0}},
		'{bffa_pkg::CMD_ALLOC, 25'd0,       24'h0,
			'{bffa_pkg::ST_FAIL, 24'h0,    13'd0}},
		'{bffa_pkg::CMD_ALLOC, 25'd1,       24'h0,
			'{bffa_pkg::ST_DONE, 24'h0,    13'd1}},
		'{bffa_pkg::CMD_ALLOC, 25'd4096,    24'h0,
			'{bffa_pkg::ST_DONE, 24'h1000, 13'd2}},
		'{bffa_pkg::CMD_ALLOC, 25'd4097,    24'h0,
			'{bffa_pkg::ST_DONE, 24'h2000, 13'd4}},
		'{bffa_pkg::CMD_FREE,  25'd0,       24'h0,
			'{bffa_pkg::ST_NULL, 24'h0,    13'd4}},
		// run from block one reaches into the next allocation
		'{bffa_pkg::CMD_FREE,  25'd0,       24'h1000,
			'{bffa_pkg::ST_DONE, 24'h0,    13'd1}},
		'{bffa_pkg::CMD_FREE,  25'd0,       24'hffffff,
			'{bffa_pkg::ST_DONE, 24'h0,    13'd1}},
		'{bffa_pkg::CMD_ALLOC, 25'h1000000, 24'h0,
			'{bffa_pkg::ST_FAIL, 24'h0,    13'd1}},
		'{bffa_pkg::CMD_FREE,  25'h1ffffff, 24'h000001,
			'{bffa_pkg::ST_DONE, 24'h0,    13'd0}},
		'{bffa_pkg::CMD_ALLOC, 25'h1000000, 24'h0,
			'{bffa_pkg::ST_DONE, 24'h0,    13'd4096}},
		'{bffa_pkg::CMD_ALLOC, 25'd1,       24'h0,
			'{bffa_pkg::ST_FAIL, 24'h0,    13'd4096}},
		'{bffa_pkg::CMD_FREE,  25'd0,       24'h000fff,
			'{bffa_pkg::ST_DONE, 24'h0,    13'd0}},
		'{bffa_pkg::CMD_NOP,   25'h1ffffff, 24'hffffff,
			'{bffa_pkg::ST_DONE, 24'h0,    13'd0}},
		'{bffa_pkg::CMD_ALLOC, 25'h1ffffff, 24'h0,
			'{bffa_pkg::ST_FAIL, 24'h0,    13'd0}}
	};

	// (total, reserved) per phase, saturating and empty maps among them
	int unsigned phase_total [8]    = '{4096, 8191, 0, 40, 4096, 200, 8191, 1};
	int unsigned phase_reserved [8] = '{0, 8191, 0, 3, 4095, 0, 0, 1};

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bffa_pkg::REG_TOTAL;
		cfg_data = '0;
		start = 1'b0;
		command = bffa_pkg::CMD_INIT;
		size_bytes = '0;
		address = '0;
		total_cfg = NBLK;
		reserved_cfg = 0;
		model_used = 0;
		allocs_ok = 0;
		frees_ok = 0;
		burst_left = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send(directed[i].cmd, directed[i].sz, directed[i].ad, 1, directed[i].want);
		drain();

		for (int p = 0; p < 8; p++) begin
			write_reg(bffa_pkg::REG_TOTAL, phase_total[p]);
			write_reg(bffa_pkg::REG_RESERVED, phase_reserved[p]);
			live_addrs.delete();
			send(bffa_pkg::CMD_INIT, '0, '0, 0, '0);
			for (int n = 0; n < N_RAND / 8; n++) random_word();
			drain();
		end

		repeat (50) @(negedge clk);
		$display("covered %0d result words over 8 map settings: %0d allocations, %0d frees",
			words_checked, allocs_ok, frees_ok);
		if (mismatches == 0 && pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d words still expected", mismatches, pending.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
